>>> design/inverse_affine_warp_nearest_defines.svh
// Assertion macros for the inverse affine warp block.
`ifndef INVERSE_AFFINE_WARP_NEAREST_DEFINES_SVH
`define INVERSE_AFFINE_WARP_NEAREST_DEFINES_SVH

`ifndef SYNTHESIS
`define IAWN_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define IAWN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define IAWN_ASSERT_IMPLIES(label, ante, cons)
`define IAWN_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> design/iawn_pkg.sv
`default_nettype none

package iawn_pkg;

  localparam int SRC_ROWS_DEF = 128;
  localparam int SRC_COLS_DEF = 128;

  localparam int COEF_W = 16;
  localparam int FRAC_W = 8;
  localparam int POS_W  = 7;
  localparam int PIX_W  = 8;
  localparam int PROD_W = 2 * COEF_W;
  localparam int NUM_W  = 34;
  localparam int DEN_W  = 32;
  localparam int Q_W    = 8;
  localparam int DS_W   = DEN_W + Q_W;
  localparam int STEP_W = 3;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [COEF_W-1:0] COEF_ONE      = 16'd256;
  localparam logic [POS_W-1:0]  ROW_LIMIT_RST = 7'd111;
  localparam logic [POS_W-1:0]  COL_LIMIT_RST = 7'd91;

  typedef enum logic [2:0] {
    REG_A11,
    REG_A12,
    REG_A21,
    REG_A22,
    REG_B1,
    REG_B2,
    REG_ROW_LIMIT,
    REG_COL_LIMIT
  } reg_idx_t;

  typedef enum logic {
    MODE_LOAD,
    MODE_QUERY
  } mode_t;

  typedef enum logic [2:0] {
    ST_PREP,
    ST_IDLE,
    ST_MUL,
    ST_DIV_ROW,
    ST_DIV_COL,
    ST_FETCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                    start;
    logic                    abort;
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den_abs;
    logic                    den_neg;
    logic [POS_W-1:0]        lim;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [POS_W-1:0] q;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> design/iawn_if.sv
`default_nettype none

interface iawn_req_if;
  import iawn_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [POS_W-1:0] row;
  logic [POS_W-1:0] col;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, mode, row, col, pixel_in, input ready);
  modport sink (input valid, mode, row, col, pixel_in, output ready);
endinterface

interface iawn_resp_if;
  import iawn_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic [POS_W-1:0] src_row;
  logic [POS_W-1:0] src_col;
  logic             singular;

  modport source (output valid, pixel_out, src_row, src_col, singular, input ready);
  modport sink (input valid, pixel_out, src_row, src_col, singular, output ready);
endinterface

`default_nettype wire

>>> design/iawn_div.sv
`default_nettype none

module iawn_div (
  input  logic               clk,
  input  logic               rst,
  input  iawn_pkg::div_req_t req,
  output iawn_pkg::div_rsp_t rsp
);
  import iawn_pkg::*;

  localparam int STEPS = Q_W + 1;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] rem;
  logic [DS_W-1:0]  ds;
  logic [Q_W-2:0]   qbits;
  logic             ovf;
  logic             zq;
  logic [POS_W-1:0] lim;
  logic             ge;
  logic             last;
  logic [NUM_W-1:0] num_abs;
  logic [Q_W-1:0]   q_full;
  logic [POS_W-1:0] q_clamped;

  always_comb begin
    num_abs = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
    ge      = {{(DS_W-NUM_W){1'b0}}, rem} >= ds;
    last    = busy && (cnt == CNT_W'(STEPS - 1));
    q_full  = {qbits, ge};
    if (zq) begin
      q_clamped = '0;
    end else if (ovf || (q_full > {1'b0, lim})) begin
      q_clamped = lim;
    end else begin
      q_clamped = q_full[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || req.abort) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (last) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
    end
  end

  // The first step only detects a quotient too large for the quotient register.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= num_abs;
      ds  <= {req.den_abs, {Q_W{1'b0}}};
      zq  <= req.num[NUM_W-1] ^ req.den_neg;
      lim <= req.lim;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - ds[NUM_W-1:0];
      end
      ds <= ds >> 1;
      if (cnt == '0) begin
        ovf <= ge;
      end else begin
        qbits <= {qbits[Q_W-3:0], ge};
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = last;
  assign rsp.q    = q_clamped;

endmodule

`default_nettype wire

>>> design/inverse_affine_warp_nearest.sv
// A load is written to the store as it is accepted; the next item is accepted in the
// following cycle. A query holds ready low from ST_MUL to ST_DONE, until its result is
// loaded into the output register, and runs the four-product multiply pass and two
// bit-serial divisions of nine steps each; a singular map sends it straight to ST_DONE.
// Reset loads the default map, then a coefficient pass in ST_PREP holds ready low; every
// register write repeats that pass. The pixel store is not cleared.
`default_nettype none
`include "inverse_affine_warp_nearest_defines.svh"

module inverse_affine_warp_nearest #(
  parameter int SRC_ROWS = iawn_pkg::SRC_ROWS_DEF,
  parameter int SRC_COLS = iawn_pkg::SRC_COLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  iawn_req_if.sink                    req,
  iawn_resp_if.source                 resp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [iawn_pkg::ADDR_W-1:0] paddr,
  input  logic [iawn_pkg::DATA_W-1:0] pwdata,
  output logic [iawn_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import iawn_pkg::*;

  localparam int DEPTH = SRC_ROWS * SRC_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [STEP_W-1:0] PREP_LAST = STEP_W'(6);
  localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(4);

  state_t state, state_next;
  logic [STEP_W-1:0] step, step_next;

  logic req_ready;
  logic accept;
  logic load_ok;
  logic store_we;
  logic mem_rd;
  logic out_load;
  logic div_start;
  logic cfg_we;
  reg_idx_t cfg_idx;

  logic signed [COEF_W-1:0] a11, a12, a21, a22, b1, b2;
  logic [POS_W-1:0] row_limit, col_limit;
  logic [POS_W-1:0] row_lim_eff, col_lim_eff;

  logic signed [COEF_W-1:0] mul_a, mul_b;
  logic signed [COEF_W-1:0] row_ext, col_ext;
  logic signed [PROD_W-1:0] prod;
  logic signed [NUM_W-1:0]  prod_ext, prod_sh;
  logic signed [NUM_W-1:0]  det, k1, k2, nr, nc;
  logic                     det_neg, det_zero;
  logic [NUM_W-1:0]         det_mag;

  logic [POS_W-1:0] q_row, q_col;
  logic [POS_W-1:0] src_row, src_col;
  logic             sing;
  logic [PIX_W-1:0] rd_data;

  logic             out_valid;
  logic [PIX_W-1:0] out_pixel;
  logic [POS_W-1:0] out_row, out_col;
  logic             out_sing;

  logic [POS_W-1:0] addr_row, addr_col;
  logic [AW-1:0]    mem_addr;
  logic [PIX_W-1:0] store [DEPTH];

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Register port.
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a11       <= COEF_ONE;
      a12       <= '0;
      a21       <= '0;
      a22       <= COEF_ONE;
      b1        <= '0;
      b2        <= '0;
      row_limit <= ROW_LIMIT_RST;
      col_limit <= COL_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_A11:       a11       <= pwdata[COEF_W-1:0];
        REG_A12:       a12       <= pwdata[COEF_W-1:0];
        REG_A21:       a21       <= pwdata[COEF_W-1:0];
        REG_A22:       a22       <= pwdata[COEF_W-1:0];
        REG_B1:        b1        <= pwdata[COEF_W-1:0];
        REG_B2:        b2        <= pwdata[COEF_W-1:0];
        REG_ROW_LIMIT: row_limit <= pwdata[POS_W-1:0];
        REG_COL_LIMIT: col_limit <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_A11:       prdata = {{(DATA_W-COEF_W){1'b0}}, a11};
      REG_A12:       prdata = {{(DATA_W-COEF_W){1'b0}}, a12};
      REG_A21:       prdata = {{(DATA_W-COEF_W){1'b0}}, a21};
      REG_A22:       prdata = {{(DATA_W-COEF_W){1'b0}}, a22};
      REG_B1:        prdata = {{(DATA_W-COEF_W){1'b0}}, b1};
      REG_B2:        prdata = {{(DATA_W-COEF_W){1'b0}}, b2};
      REG_ROW_LIMIT: prdata = {{(DATA_W-POS_W){1'b0}}, row_limit};
      REG_COL_LIMIT: prdata = {{(DATA_W-POS_W){1'b0}}, col_limit};
      default:       prdata = '0;
    endcase
  end

  // A limit past the edge of the store clamps to the last row or column.
  assign row_lim_eff = (int'(row_limit) > SRC_ROWS - 1) ? POS_W'(SRC_ROWS - 1) : row_limit;
  assign col_lim_eff = (int'(col_limit) > SRC_COLS - 1) ? POS_W'(SRC_COLS - 1) : col_limit;

  // Control.
  assign accept  = req.valid && req_ready;
  assign load_ok = (int'(req.row) < SRC_ROWS) && (int'(req.col) < SRC_COLS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_PREP;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    req_ready  = 1'b0;
    store_we   = 1'b0;
    mem_rd     = 1'b0;
    out_load   = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_PREP: begin
        step_next = step + 1'b1;
        if (step == PREP_LAST) begin
          state_next = ST_IDLE;
          step_next  = '0;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (accept) begin
          if (req.mode == MODE_QUERY) begin
            step_next  = '0;
            state_next = det_zero ? ST_DONE : ST_MUL;
          end else begin
            store_we = load_ok;
          end
        end
      end
      ST_MUL: begin
        step_next = step + 1'b1;
        if (step == MUL_LAST) begin
          div_start  = 1'b1;
          state_next = ST_DIV_ROW;
          step_next  = '0;
        end
      end
      ST_DIV_ROW: begin
        if (div_rsp.done) begin
          div_start  = 1'b1;
          state_next = ST_DIV_COL;
        end
      end
      ST_DIV_COL: begin
        if (div_rsp.done) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        mem_rd     = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || resp.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        step_next  = '0;
      end
    endcase
    if (cfg_we) begin
      state_next = ST_PREP;
      step_next  = '0;
    end
  end

  assign req.ready = req_ready;

  // Shared multiplier. The map-only terms are formed after every register write;
  // a query then needs only its four position products.
  assign row_ext = signed'({{(COEF_W-POS_W){1'b0}}, q_row});
  assign col_ext = signed'({{(COEF_W-POS_W){1'b0}}, q_col});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_PREP) begin
      case (step)
        3'd0: begin mul_a = a11; mul_b = a22; end
        3'd1: begin mul_a = a12; mul_b = a21; end
        3'd2: begin mul_a = a12; mul_b = b2; end
        3'd3: begin mul_a = a22; mul_b = b1; end
        3'd4: begin mul_a = a21; mul_b = b1; end
        3'd5: begin mul_a = a11; mul_b = b2; end
        default: ;
      endcase
    end else begin
      case (step)
        3'd0: begin mul_a = a22; mul_b = row_ext; end
        3'd1: begin mul_a = a12; mul_b = col_ext; end
        3'd2: begin mul_a = a11; mul_b = col_ext; end
        3'd3: begin mul_a = a21; mul_b = row_ext; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign prod_ext = {{(NUM_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign prod_sh  = prod_ext <<< FRAC_W;

  assign det_neg  = det[NUM_W-1];
  assign det_zero = (det == '0);
  assign det_mag  = det_neg ? NUM_W'(-det) : NUM_W'(det);

  always_ff @(posedge clk) begin
    case (state)
      ST_PREP: begin
        case (step)
          3'd1: det <= prod_ext;
          3'd2: det <= det - prod_ext;
          3'd3: k1  <= prod_ext;
          3'd4: k1  <= k1 - prod_ext;
          3'd5: k2  <= prod_ext;
          3'd6: k2  <= k2 - prod_ext;
          default: ;
        endcase
      end
      ST_IDLE: begin
        if (accept) begin
          q_row <= req.row;
          q_col <= req.col;
          sing  <= det_zero;
          if (det_zero) begin
            src_row <= '0;
            src_col <= '0;
          end
        end
      end
      ST_MUL: begin
        case (step)
          3'd1: nr <= k1 + prod_sh;
          3'd2: nr <= nr - prod_sh;
          3'd3: nc <= k2 + prod_sh;
          3'd4: nc <= nc - prod_sh;
          default: ;
        endcase
      end
      ST_DIV_ROW: begin
        if (div_rsp.done) begin
          src_row <= div_rsp.q;
        end
      end
      ST_DIV_COL: begin
        if (div_rsp.done) begin
          src_col <= div_rsp.q;
        end
      end
      default: ;
    endcase
  end

  // Serial divider, shared by the row and the column quotient.
  always_comb begin
    div_req.start   = div_start;
    div_req.abort   = cfg_we;
    div_req.num     = (state == ST_MUL) ? nr : nc;
    div_req.den_abs = det_mag[DEN_W-1:0];
    div_req.den_neg = det_neg;
    div_req.lim     = (state == ST_MUL) ? row_lim_eff : col_lim_eff;
  end

  iawn_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Pixel store.
  assign addr_row = (state == ST_FETCH) ? src_row : req.row;
  assign addr_col = (state == ST_FETCH) ? src_col : req.col;
  assign mem_addr = AW'(int'(addr_row) * SRC_COLS + int'(addr_col));

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[mem_addr] <= req.pixel_in;
    end
    if (mem_rd) begin
      rd_data <= store[mem_addr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (resp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixel <= sing ? '0 : rd_data;
      out_row   <= src_row;
      out_col   <= src_col;
      out_sing  <= sing;
    end
  end

  assign resp.valid     = out_valid;
  assign resp.pixel_out = out_pixel;
  assign resp.src_row   = out_row;
  assign resp.src_col   = out_col;
  assign resp.singular  = out_sing;

  `IAWN_ASSERT_IMPLIES(a_ready_div_idle, req.ready, !div_rsp.busy)
  `IAWN_ASSERT_NEXT(a_query_leaves_idle, req.valid && req.ready && req.mode == MODE_QUERY, state != ST_IDLE)
  `IAWN_ASSERT_NEXT(a_write_restarts_prep, cfg_we, state == ST_PREP && step == '0)

endmodule

`default_nettype wire

>>> tb/sv/inverse_affine_warp_nearest_tb.sv
`timescale 1ns / 1ps

module inverse_affine_warp_nearest_tb;
  import iawn_pkg::*;

  localparam int SETTLE_CYCLES = 30;
  localparam int STORE_DEPTH = SRC_ROWS_DEF * SRC_COLS_DEF;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic [POS_W-1:0] src_row;
    logic [POS_W-1:0] src_col;
    logic             singular;
  } warp_result_t;

  typedef struct packed {
    bit               is_cfg;
    reg_idx_t         idx;
    logic [15:0]      wval;
    mode_t            mode;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [PIX_W-1:0] pix;
    bit               typed;
    warp_result_t     want;
  } dir_step_t;

  typedef enum int {
    MAP_NEAR,
    MAP_RANDOM,
    MAP_SINGULAR,
    MAP_CORNER
  } map_kind_t;

  bit clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  iawn_req_if req_ch ();
  iawn_resp_if resp_ch ();

  inverse_affine_warp_nearest DUT (
    .clk    (clk),
    .rst    (rst),
    .req    (req_ch),
    .resp   (resp_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  logic [15:0] map_coef [6];
  logic [POS_W-1:0] lim_row;
  logic [POS_W-1:0] lim_col;
  logic [PIX_W-1:0] img_model [STORE_DEPTH];
  bit img_written [STORE_DEPTH];
  warp_result_t pending_warps [$];
  int mismatch_count;
  bit src_calm;
  bit sink_calm;

  logic [15:0] corner_vals [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0100, 16'hFF00};

  dir_step_t dir_steps [26] = '{
    '{1'b0, REG_A11, 16'h0000, MODE_LOAD, 7'd0, 7'd0, 8'hFF, 1'b0, '{8'h00, 7'd0, 7'd0, 1'b0}},
    '{1'b0, REG_A11, 16'h0000, MODE_QUERY, 7'd0, 7'd0, 8'h00, 1'b1, '{8'hFF, 7'd0, 7'd0, 1'b0}},
    '{1'b0, REG_A11, 16'h0000, MODE_LOAD, 7'd111, 7'd91, 8'h5A, 1'b0, '{8'h00, 7'd0, 7'd0, 1'b0}},
    '{1'b0, REG_A11, 16'h0000, MODE_LOAD, 7'd127, 7'd127, 8'hA5, 1'b0, '{8'h00, 7'd0, 7'd0, 1'b0}},
    '{1'b0, REG_A11, 16'h0000, MODE_QUERY, 7'd127, 7'd127, 8'hFF, 1'b1,
      '{8'h5A, 7'd111, 7'd91, 1'b0}},
    '{1'b0, REG_A11, 16'h0000, MODE_QUERY, 7'd64, 7'd33, 8'h3C, 1'b0, '{8'h00, 7'd0, 7'd0, 1'b0}},
    '{1'b1, REG_ROW_LIMIT, 16'd127, MODE_LOAD, 7'd0, 7'd0, 8'h00, 1'b0, '{8'h00, 7'd0, 7'd0, 1'b0}},
    '{1'b1, REG_COL_LIMIT, 16'd127, MODE_LOAD, 7'd0, 7'd0, 8'h00, 1'b0, '{8'h00, 7'd0, 7'd0, 1'b0}},
    '{1'b0, REG_A11, 16'h0000, MODE_QUERY, 7'd127, 7'd127, 8'h00, 1'b1,
      '{8'hA5, 7'd127, 7'd127, 1'b0}},
    '{1'b1, REG_ROW_LIMIT, 16'd0, MODE_LOAD, 7'd0, 7'd0, 8'h00, 1'b0, '{8'h00, 7'd0, 7'd0, 1'b0}},
    '{1'b1, REG_COL_LIMIT, 16'd0, MODE_LOAD, 7'd0, 7'd0, 8'h00, 1'b0, '{8'h00, 7'd0, 7'd0, 1'b0}},
    '{1'b0, REG_A11, 16'h0000, MODE_QUERY, 7'd127, 7'd127, 8'h00, 1'b1,
      '{8'hFF, 7'd0, 7'd0, 1'b0}},
    '{1'b1, REG_ROW_LIMIT, 16'd127, MODE_LOAD, 7'd0, 7'd0, 8'h00, 1'b0, '{8'h00, 7'd0, 7'd0, 1'b0}},
    '{1'b1, REG_COL_LIMIT, 16'd127, MODE_LOAD, 7'd0, 7'd0, 8'h00, 1'b0, '{8'h00, 7'd0, 7'd0, 1'b0}},
    '{1'b1, REG_B1, 16'h7FFF, MODE_LOAD, 7'd0, 7'd0, 8'h00, 1'b0, '{8'h00, 7'd0, 7'd0, 1'b0}},
    '{1'b0, REG_A11, 16'h0000, MODE_QUERY, 7'd5, 7'd5, 8'h81, 1'b0, '{8'h00, 7'd0, 7'd0, 1'b0}},
    '{1'b0, REG_A11, 16'h0000, MODE_QUERY, 7'd127, 7'd0, 8'h7E, 1'b0, '{8'h00, 7'd0, 7'd0, 1'b0}},
    '{1'b1, REG_B1, 16'h0000, MODE_LOAD, 7'd0, 7'd0, 8'h00, 1'b0, '{8'h00, 7'd0, 7'd0, 1'b0}},
    '{1'b1, REG_A22, 16'h8000, MODE_LOAD, 7'd0, 7'd0, 8'h00, 1'b0, '{8'h00, 7'd0, 7'd0, 1'b0}},
    '{1'b0, REG_A11, 16'h0000, MODE_QUERY, 7'd127, 7'd127, 8'h00, 1'b0, '{8'h00, 7'd0, 7'd0, 1'b0}},
    '{1'b1, REG_A12, 16'h7FFF, MODE_LOAD, 7'd0, 7'd0, 8'h00, 1'b0, '{8'h00, 7'd0, 7'd0, 1'b0}},
    '{1'b0, REG_A11, 16'h0000, MODE_QUERY, 7'd3, 7'd100, 8'h00, 1'b0, '{8'h00, 7'd0, 7'd0, 1'b0}},
    '{1'b1, REG_A11, 16'h0000, MODE_LOAD, 7'd0, 7'd0, 8'h00, 1'b0, '{8'h00, 7'd0, 7'd0, 1'b0}},
    '{1'b1, REG_A12, 16'h0000, MODE_LOAD, 7'd0, 7'd0, 8'h00, 1'b0, '{8'h00, 7'd0, 7'd0, 1'b0}},
    '{1'b0, REG_A11, 16'h0000, MODE_QUERY, 7'd127, 7'd0, 8'hFF, 1'b1, '{8'h00, 7'd0, 7'd0, 1'b1}},
    '{1'b0, REG_A11, 16'h0000, MODE_QUERY, 7'd0, 7'd127, 8'h00, 1'b1, '{8'h00, 7'd0, 7'd0, 1'b1}}
  };

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [POS_W-1:0] clamp_coord(longint q, logic [POS_W-1:0] lim, int size);
    longint top;
    top = (int'(lim) > size - 1) ? longint'(size - 1) : longint'(lim);
    if (q < 0) return '0;
    if (q > top) return POS_W'(top);
    return POS_W'(q);
  endfunction

  function automatic warp_result_t predict_warp(logic [POS_W-1:0] r, logic [POS_W-1:0] c);
    longint a11, a12, a21, a22, b1, b2, det, nr, nc, ri, ci;
    warp_result_t res;
    a11 = longint'($signed(map_coef[REG_A11]));
    a12 = longint'($signed(map_coef[REG_A12]));
    a21 = longint'($signed(map_coef[REG_A21]));
    a22 = longint'($signed(map_coef[REG_A22]));
    b1 = longint'($signed(map_coef[REG_B1]));
    b2 = longint'($signed(map_coef[REG_B2]));
    ri = longint'(r);
    ci = longint'(c);
    res = '0;
    det = a11 * a22 - a12 * a21;
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    nr = 256 * (a22 * ri - a12 * ci) + a12 * b2 - a22 * b1;
    nc = 256 * (a11 * ci - a21 * ri) + a21 * b1 - a11 * b2;
    res.src_row = clamp_coord(nr / det, lim_row, SRC_ROWS_DEF);
    res.src_col = clamp_coord(nc / det, lim_col, SRC_COLS_DEF);
    res.pixel_out = img_model[int'(res.src_row) * SRC_COLS_DEF + int'(res.src_col)];
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // The request side drives at the falling edge and the transaction completes at the rising edge.
  task automatic send_item(input mode_t m, input logic [POS_W-1:0] r,
                           input logic [POS_W-1:0] c, input logic [PIX_W-1:0] p);
    int gap;
    if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.mode = m;
    req_ch.row = r;
    req_ch.col = c;
    req_ch.pixel_in = p;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    if (m == MODE_LOAD) begin
      img_model[int'(r) * SRC_COLS_DEF + int'(c)] = p;
      img_written[int'(r) * SRC_COLS_DEF + int'(c)] = 1'b1;
    end
  endtask

  // A query never reads a pixel that was never loaded, so the needed pixel is loaded first.
  task automatic run_query(input logic [POS_W-1:0] r, input logic [POS_W-1:0] c,
                           input logic [PIX_W-1:0] p, input bit typed, input warp_result_t want);
    warp_result_t res;
    res = predict_warp(r, c);
    if (!res.singular && !img_written[int'(res.src_row) * SRC_COLS_DEF + int'(res.src_col)]) begin
      send_item(MODE_LOAD, res.src_row, res.src_col, PIX_W'($urandom));
      res = predict_warp(r, c);
    end
    send_item(MODE_QUERY, r, c, p);
    pending_warps.push_back(typed ? want : res);
  endtask

  task automatic settle_block();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_warps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] v);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = DATA_W'(v);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_ROW_LIMIT: lim_row = v[POS_W-1:0];
      REG_COL_LIMIT: lim_col = v[POS_W-1:0];
      default: map_coef[idx] = v;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  initial begin
    int stall;
    warp_result_t want;
    resp_ch.ready = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
      stall = sink_calm ? 0 : $urandom_range(0, 15);
      @(negedge clk);
      if (stall > 0) begin
        resp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      resp_ch.ready = 1'b1;
      do @(posedge clk); while (resp_ch.valid !== 1'b1);
      if (pending_warps.size() == 0) begin
        report_mismatch("result transaction with no query pending");
      end else begin
        want = pending_warps.pop_front();
        if (resp_ch.pixel_out !== want.pixel_out)
          report_mismatch($sformatf("pixel_out %0h, expected %0h", resp_ch.pixel_out,
                                    want.pixel_out));
        if (resp_ch.src_row !== want.src_row)
          report_mismatch($sformatf("src_row %0d, expected %0d", resp_ch.src_row, want.src_row));
        if (resp_ch.src_col !== want.src_col)
          report_mismatch($sformatf("src_col %0d, expected %0d", resp_ch.src_col, want.src_col));
        if (resp_ch.singular !== want.singular)
          report_mismatch($sformatf("singular %0b, expected %0b", resp_ch.singular,
                                    want.singular));
      end
    end
  end

  initial begin
    logic [15:0] coefs [6];
    map_kind_t kind;
    int lim_pick;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_LOAD;
    req_ch.row = '0;
    req_ch.col = '0;
    req_ch.pixel_in = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    map_coef = '{COEF_ONE, 16'h0000, 16'h0000, COEF_ONE, 16'h0000, 16'h0000};
    lim_row = ROW_LIMIT_RST;
    lim_col = COL_LIMIT_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_steps[i]) begin
      if (dir_steps[i].is_cfg) begin
        settle_block();
        write_reg(dir_steps[i].idx, dir_steps[i].wval);
      end else if (dir_steps[i].mode == MODE_LOAD) begin
        send_item(MODE_LOAD, dir_steps[i].row, dir_steps[i].col, dir_steps[i].pix);
      end else begin
        run_query(dir_steps[i].row, dir_steps[i].col, dir_steps[i].pix,
                  dir_steps[i].typed, dir_steps[i].want);
      end
    end

    for (int p = 0; p < 10; p++) begin
      settle_block();
      kind = (p % 2 == 0) ? MAP_NEAR : map_kind_t'(1 + (p / 2) % 3);
      case (kind)
        MAP_NEAR: begin
          coefs[REG_A11] = 16'($urandom_range(128, 512));
          coefs[REG_A22] = 16'($urandom_range(128, 512));
          if ($urandom_range(0, 3) == 0) coefs[REG_A11] = -coefs[REG_A11];
          if ($urandom_range(0, 3) == 0) coefs[REG_A22] = -coefs[REG_A22];
          coefs[REG_A12] = 16'($urandom_range(0, 256)) - 16'd128;
          coefs[REG_A21] = 16'($urandom_range(0, 256)) - 16'd128;
          coefs[REG_B1] = 16'($urandom_range(0, 16384)) - 16'd8192;
          coefs[REG_B2] = 16'($urandom_range(0, 16384)) - 16'd8192;
        end
        MAP_RANDOM: begin
          foreach (coefs[k]) coefs[k] = 16'($urandom);
        end
        MAP_SINGULAR: begin
          foreach (coefs[k]) coefs[k] = 16'($urandom);
          coefs[REG_A21] = coefs[REG_A11];
          coefs[REG_A22] = coefs[REG_A12];
        end
        default: begin
          foreach (coefs[k]) coefs[k] = corner_vals[$urandom_range(0, 5)];
        end
      endcase
      for (int k = REG_A11; k <= REG_B2; k++) write_reg(reg_idx_t'(k), coefs[k]);
      for (int k = REG_ROW_LIMIT; k <= REG_COL_LIMIT; k++) begin
        lim_pick = $urandom_range(0, 3);
        write_reg(reg_idx_t'(k), (lim_pick == 0) ? 16'd0 :
                                 (lim_pick == 1) ? 16'd127 : 16'($urandom_range(0, 127)));
      end
      repeat (80) begin
        if ($urandom_range(0, 9) < 4)
          send_item(MODE_LOAD, POS_W'($urandom), POS_W'($urandom), PIX_W'($urandom));
        else
          run_query(POS_W'($urandom), POS_W'($urandom), PIX_W'($urandom), 1'b0, '0);
      end
    end

    settle_block();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("[inverse_affine_warp_nearest] OK");
    else
      $display("[inverse_affine_warp_nearest] ERROR");
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("[inverse_affine_warp_nearest] ERROR");
    $finish;
  end

endmodule

>>> inverse_affine_warp_nearest.f
+incdir+design
design/iawn_pkg.sv
design/iawn_if.sv
design/iawn_div.sv
design/inverse_affine_warp_nearest.sv
tb/sv/inverse_affine_warp_nearest_tb.sv
